@@ rtl/i2cm_pkg.sv @@
// Shared types and constants of the I2C master byte engine.
// No dependencies; imported by the front, the back end and the top level.
package i2cm_pkg;

  // Command codes carried in the action field; CMD_IDLE and the unlisted codes are ticks
  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_START_FAIL = 2'd1;
  localparam logic [1:0] ST_NO_ACK     = 2'd2;
  localparam logic [1:0] ST_REJECTED   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHASE_TICKS   = 2'd0;
  localparam logic [1:0] CFG_WRITE_PROTECT = 2'd1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

  // Request after classification, as held in the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [15:0] phase_ticks;
    logic        write_protect;
  } cfg_t;

  // One result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
    logic       wp_out;
  } result_t;

endpackage

@@ rtl/i2cm_front.sv @@
// Front of the I2C master byte engine: classifies each request as tick or
// command and holds it in a short queue. Depends on i2cm_pkg.
module i2cm_front import i2cm_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_in_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t              entries_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push, pop;
  item_t              item_new;

  // Actions outside the command range act as ticks
  always_comb begin
    item_new.is_cmd  = (action_i >= CMD_START) && (action_i <= CMD_READ_NACK);
    item_new.cmd     = action_i;
    item_new.tx_byte = tx_byte_i;
    item_new.sda_in  = sda_in_i;
  end

  assign in_ready_o   = (count_q != CntW'(Depth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = entries_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

@@ rtl/i2cm_back.sv @@
// Back end of the I2C master byte engine: runs the bus phase sequencer one request
// per cycle unless the result stalls, and holds the result register. Depends on i2cm_pkg.
module i2cm_back import i2cm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  input  cfg_t    cfg_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  localparam logic [4:0] STEP_WR_ACK_LOW = 5'd24;
  localparam logic [4:0] STEP_WR_ACK_REL = 5'd25;
  localparam logic [4:0] STEP_WR_SAMPLE  = 5'd26;
  localparam logic [4:0] STEP_RD_BITS    = 5'd16;
  localparam logic [4:0] STEP_RD_ACK_DRV = 5'd17;
  localparam logic [4:0] STEP_RD_ACK_SCL = 5'd18;
  localparam logic [4:0] STEP_RD_LAST    = 5'd19;
  localparam logic [1:0] SUB_LAST        = 2'd2;

  // Index of the final phase of each command
  function automatic logic [4:0] last_step(input logic [2:0] cmd);
    case (cmd)
      CMD_START:     last_step = 5'd2;
      CMD_STOP:      last_step = 5'd3;
      CMD_WRITE:     last_step = 5'd26;
      CMD_READ_ACK:  last_step = 5'd19;
      CMD_READ_NACK: last_step = 5'd19;
      default:       last_step = 5'd0;
    endcase
  endfunction

  logic [2:0]  cmd_q, cmd_d;
  logic [4:0]  step_q, step_d;
  logic [1:0]  sub_q, sub_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  rx_q, rx_d;
  logic        out_valid_q;
  result_t     result_q;

  logic        pop;
  logic        done;
  logic        fin;
  logic        enter;
  logic [15:0] limit;
  logic [15:0] tick_inc;

  assign pop        = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = pop;
  assign limit      = (cfg_i.phase_ticks == '0) ? 16'd1 : cfg_i.phase_ticks;
  assign tick_inc   = tick_q + 16'd1;

  always_comb begin
    cmd_d    = cmd_q;
    step_d   = step_q;
    sub_d    = sub_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    status_d = status_q;
    rx_d     = rx_q;
    done     = 1'b0;
    fin      = 1'b0;
    enter    = 1'b0;

    if (item_i.is_cmd) begin
      if (cmd_q != CMD_IDLE) begin
        status_d = ST_REJECTED;
      end else begin
        cmd_d    = item_i.cmd;
        step_d   = '0;
        sub_d    = '0;
        tick_d   = '0;
        status_d = ST_OK;
        if (item_i.cmd == CMD_WRITE) begin
          shift_d = item_i.tx_byte;
        end
        if (item_i.cmd == CMD_READ_ACK || item_i.cmd == CMD_READ_NACK) begin
          shift_d = '0;
          sda_d   = 1'b1;
        end
        enter = 1'b1;
      end
    end else if (cmd_q != CMD_IDLE) begin
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = '0;
        // close the current phase
        case (cmd_q)
          CMD_START: begin
            if ((step_q == 5'd0 && !item_i.sda_in) || (step_q == 5'd1 && item_i.sda_in)) begin
              status_d = ST_START_FAIL;
              fin      = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_q < STEP_WR_ACK_LOW && sub_q == SUB_LAST) begin
              shift_d = {shift_q[6:0], 1'b0};
            end else if (step_q == STEP_WR_SAMPLE) begin
              status_d = item_i.sda_in ? ST_NO_ACK : ST_OK;
              scl_d    = 1'b0;
            end
          end
          CMD_READ_ACK, CMD_READ_NACK: begin
            if (step_q < STEP_RD_BITS && step_q[0]) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
            end
            if (step_q == STEP_RD_LAST) begin
              rx_d = shift_q;
            end
          end
          default: ;
        endcase
        if (step_q == last_step(cmd_q)) begin
          fin = 1'b1;
        end
        if (fin) begin
          cmd_d  = CMD_IDLE;
          step_d = '0;
          done   = 1'b1;
        end else begin
          step_d = step_q + 5'd1;
          sub_d  = (sub_q == SUB_LAST) ? 2'd0 : sub_q + 2'd1;
          enter  = 1'b1;
        end
      end
    end

    // open the next phase: set the line it drives
    if (enter) begin
      case (cmd_d)
        CMD_START: begin
          if (step_d == 5'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b0;
          end
        end
        CMD_STOP: begin
          if (step_d == 5'd0) begin
            scl_d = 1'b0;
          end else if (step_d == 5'd1) begin
            sda_d = 1'b0;
          end else if (step_d == 5'd2) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (step_d < STEP_WR_ACK_LOW) begin
            if (sub_d == 2'd0) begin
              scl_d = 1'b0;
            end else if (sub_d == 2'd1) begin
              sda_d = shift_d[7];
            end else begin
              scl_d = 1'b1;
            end
          end else if (step_d == STEP_WR_ACK_LOW) begin
            scl_d = 1'b0;
          end else if (step_d == STEP_WR_ACK_REL) begin
            sda_d = 1'b1;
          end else begin
            scl_d = 1'b1;
          end
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          if (step_d < STEP_RD_BITS) begin
            scl_d = step_d[0];
          end else if (step_d == STEP_RD_BITS) begin
            scl_d = 1'b0;
          end else if (step_d == STEP_RD_ACK_DRV) begin
            sda_d = (cmd_d != CMD_READ_ACK);
          end else if (step_d == STEP_RD_ACK_SCL) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_IDLE;
      step_q      <= '0;
      sub_q       <= '0;
      tick_q      <= '0;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      status_q    <= ST_OK;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cmd_q    <= cmd_d;
        step_q   <= step_d;
        sub_q    <= sub_d;
        tick_q   <= tick_d;
        shift_q  <= shift_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        status_q <= status_d;
        rx_q     <= rx_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      result_q.scl_out  <= scl_d;
      result_q.sda_out  <= sda_d;
      result_q.busy_res <= (cmd_d != CMD_IDLE);
      result_q.done_res <= done;
      result_q.status   <= status_d;
      result_q.rx_byte  <= rx_d;
      result_q.wp_out   <= cfg_i.write_protect;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

@@ rtl/i2c_master_byte_engine_core.sv @@
// Top level of the I2C master byte engine: configuration registers, the
// classifying front with its queue, and the phase sequencer. Uses i2cm_pkg.
//
// Every request, tick or command, yields exactly one result. The block
// sustains one request per clock: the phase sequencer updates its state for
// each request it pops, so the only limits are the queue between front and
// back (QueueDepth entries, two by default) and the one-entry result register.
// An accepted request enters the queue, and its result is registered when
// the sequencer pops it; back-pressure on the result fills the queue,
// after which in_ready_o drops. Each bus phase lasts phase_ticks tick requests
// (zero acts as one) and SDA is taken from the tick that ends a phase. A
// command that arrives while another runs is rejected with status 3 and does
// not advance the sequence. Write configuration only while the block is idle.
module i2c_master_byte_engine_core import i2cm_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [7:0]  rx_byte_o,
  output logic        wp_out_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] phase_ticks_q;
  logic        write_protect_q;
  cfg_t        cfg;
  logic        item_valid;
  item_t       item;
  logic        item_pop;
  result_t     result;

  // Always take configuration writes; indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q   <= PHASE_TICKS_RST;
      write_protect_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PHASE_TICKS) begin
        phase_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_WRITE_PROTECT) begin
        write_protect_q <= cfg_data_i[0];
      end
    end
  end

  assign cfg.phase_ticks   = phase_ticks_q;
  assign cfg.write_protect = write_protect_q;

  // Classify and queue requests
  i2cm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .tx_byte_i    (tx_byte_i),
    .sda_in_i     (sda_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Advance the bus phase sequencer and register the result
  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign scl_out_o  = result.scl_out;
  assign sda_out_o  = result.sda_out;
  assign busy_res_o = result.busy_res;
  assign done_res_o = result.done_res;
  assign status_o   = result.status;
  assign rx_byte_o  = result.rx_byte;
  assign wp_out_o   = result.wp_out;

endmodule

@@ test/i2c_master_byte_engine_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master byte engine core.
// Predicts every result from the request stream and the register writes; needs only the RTL
// and i2cm_pkg for the command, status and register codes.
module i2c_master_byte_engine_core_tb;
  import i2cm_pkg::*;

  // Unused action codes, which the engine treats as ticks
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One row of the directed table: either a request (repeated reps times) or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  action;
    logic [7:0]  tx;
    logic        sda;
    logic [7:0]  reps;
    logic        typed;
    result_t     want;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [7:0]  tx_byte_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic [7:0]  rx_byte_o;
  logic        wp_out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  i2c_master_byte_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .status_o    (status_o),
    .rx_byte_o   (rx_byte_o),
    .wp_out_o    (wp_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus engine predictor: its own copy of the configuration and sequencer state
  // ---------------------------------------------------------------------------
  logic [15:0] phase_len  = PHASE_TICKS_RST;
  logic        wp_level   = 1'b0;
  logic [2:0]  bus_cmd    = CMD_IDLE;
  logic [5:0]  bus_step   = '0;
  logic [15:0] tick_cnt   = '0;
  logic [7:0]  shifter    = '0;
  logic        scl_drv    = 1'b1;
  logic        sda_drv    = 1'b1;
  logic [1:0]  bus_status = ST_OK;
  logic [7:0]  rx_latched = '0;

  // Results still owed by the engine, oldest first
  result_t     expected_q[$];

  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  // Set the line drives at the opening of the current phase
  function automatic void drive_for_phase();
    case (bus_cmd)
      CMD_START: begin
        if (bus_step == 0) begin
          scl_drv = 1'b1;
          sda_drv = 1'b1;
        end else begin
          sda_drv = 1'b0;
        end
      end
      CMD_STOP: begin
        case (bus_step)
          6'd0: scl_drv = 1'b0;
          6'd1: sda_drv = 1'b0;
          6'd2: scl_drv = 1'b1;
          default: sda_drv = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        if (bus_step < 24) begin
          case (bus_step % 3)
            0: scl_drv = 1'b0;
            1: sda_drv = shifter[7];
            default: scl_drv = 1'b1;
          endcase
        end else if (bus_step == 24) begin
          scl_drv = 1'b0;
        end else if (bus_step == 25) begin
          sda_drv = 1'b1;
        end else begin
          scl_drv = 1'b1;
        end
      end
      default: begin
        // both read flavours: clock out eight bits, then the acknowledge slot
        if (bus_step < 16) begin
          scl_drv = bus_step[0];
        end else if (bus_step == 16) begin
          scl_drv = 1'b0;
        end else if (bus_step == 17) begin
          sda_drv = (bus_cmd == CMD_READ_NACK);
        end else if (bus_step == 18) begin
          scl_drv = 1'b1;
        end else begin
          scl_drv = 1'b0;
        end
      end
    endcase
  endfunction

  // Advance the predictor by one request and return the result it must produce
  function automatic result_t next_bus_result(input logic [2:0] act, input logic [7:0] tx,
                                              input logic sda);
    logic        finished;
    logic [15:0] lim;
    result_t     r;
    finished = 1'b0;
    if (act >= CMD_START && act <= CMD_READ_NACK) begin
      if (bus_cmd != CMD_IDLE) begin
        bus_status = ST_REJECTED;
      end else begin
        bus_cmd    = act;
        bus_step   = '0;
        tick_cnt   = '0;
        bus_status = ST_OK;
        if (act == CMD_WRITE) shifter = tx;
        if (act == CMD_READ_ACK || act == CMD_READ_NACK) begin
          shifter = '0;
          sda_drv = 1'b1;
        end
        drive_for_phase();
      end
    end else if (bus_cmd != CMD_IDLE) begin
      lim = (phase_len == 16'd0) ? 16'd1 : phase_len;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        // close the phase; SDA is taken from this tick
        case (bus_cmd)
          CMD_START: begin
            if ((bus_step == 0 && !sda) || (bus_step == 1 && sda)) begin
              bus_status = ST_START_FAIL;
              finished = 1'b1;
            end
            if (bus_step == 2) finished = 1'b1;
          end
          CMD_STOP: begin
            if (bus_step == 3) finished = 1'b1;
          end
          CMD_WRITE: begin
            if (bus_step < 24 && bus_step % 3 == 2) begin
              shifter = {shifter[6:0], 1'b0};
            end else if (bus_step == 26) begin
              bus_status = sda ? ST_NO_ACK : ST_OK;
              scl_drv = 1'b0;
              finished = 1'b1;
            end
          end
          default: begin
            if (bus_step < 16 && bus_step[0]) shifter = {shifter[6:0], sda};
            if (bus_step == 19) begin
              rx_latched = shifter;
              finished = 1'b1;
            end
          end
        endcase
        if (finished) begin
          bus_cmd  = CMD_IDLE;
          bus_step = '0;
        end else begin
          bus_step = bus_step + 6'd1;
          drive_for_phase();
        end
      end
    end
    r = '{scl_drv, sda_drv, bus_cmd != CMD_IDLE, finished, bus_status, rx_latched, wp_level};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Present one request, hold it until accepted, then record what it must produce.
  // Returns just after the accepting edge with valid still high.
  task automatic issue_request(input logic [2:0] act, input logic [7:0] tx, input logic sda,
                               input logic use_typed = 1'b0, input result_t typed = '0);
    result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    tx_byte_i  <= tx;
    sda_in_i   <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = next_bus_result(act, tx, sda);
    expected_q.push_back(use_typed ? typed : predicted);
    requests_sent++;
  endtask

  function automatic logic [2:0] pick_tick_action();
    case ($urandom_range(0, 9))
      8: return ACT_SPARE_LO;
      9: return ACT_SPARE_HI;
      default: return CMD_IDLE;
    endcase
  endfunction

  // Mostly let SDA follow our own drive, as a quiet bus would; otherwise random
  function automatic logic pick_sda();
    return $urandom_range(0, 1) ? sda_drv : 1'($urandom_range(0, 1));
  endfunction

  // Finish any running command, let every result come back, then write one register
  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    while (bus_cmd != CMD_IDLE) begin
      issue_request(pick_tick_action(), 8'($urandom_range(0, 255)), pick_sda());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_PHASE_TICKS) begin
      phase_len = data;
    end else if (idx == CFG_WRITE_PROTECT) begin
      wp_level = data[0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly complete commands with random content, tick streams that run them to the end and
  // the odd command thrown in while busy; the rest is raw noise that can leave a command half
  // done, so the next one is rejected
  task automatic run_bus_traffic(input int unsigned n_requests);
    int unsigned target;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        issue_request(3'($urandom_range(CMD_START, CMD_READ_NACK)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        while (bus_cmd != CMD_IDLE) begin
          if ($urandom_range(0, 99) < 3) begin
            issue_request(3'($urandom_range(CMD_START, CMD_READ_NACK)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          issue_request(pick_tick_action(), 8'($urandom_range(0, 255)), pick_sda());
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  function automatic dir_row_t req_row(input logic [2:0] act, input logic [7:0] tx,
                                       input logic sda, input logic [7:0] reps);
    dir_row_t r;
    r = '0;
    r.action = act;
    r.tx     = tx;
    r.sda    = sda;
    r.reps   = reps;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [2:0] act, input logic [7:0] tx,
                                       input logic sda, input result_t want);
    dir_row_t r;
    r = req_row(act, tx, sda, 8'd1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg   = 1'b1;
    r.cfg_idx  = idx;
    r.cfg_data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and a check of every accepted result
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("t=%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("t=%0t: result with nothing expected, got scl %0b sda %0b busy %0b done %0b",
                 $time, scl_out_o, sda_out_o, busy_res_o, done_res_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("scl_out", want.scl_out, scl_out_o);
        check_field("sda_out", want.sda_out, sda_out_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("status", want.status, status_o);
        check_field("rx_byte", want.rx_byte, rx_byte_o);
        check_field("wp_out", want.wp_out, wp_out_o);
      end
    end
  end

  // Hard stop for a hung handshake or results that never come
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("i2c_master_byte_engine_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t directed_rows[$];
    dir_row_t row;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = CMD_IDLE;
    tx_byte_i   = '0;
    sda_in_i    = 1'b1;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PHASE_TICKS;
    cfg_data_i  = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Fields of typed results: scl, sda, busy, done, status, rx, wp.
    // Idle ticks at reset values, then a phase length of zero (acts as one) so that every
    // command runs quickly: busy rejection, both start failures, stop, writes of all-ones
    // with NACK and all-zeros with ACK, reads of all-ones and all-zeros.
    directed_rows = '{
      chk_row(CMD_IDLE, 8'h00, 1'b1, result_t'{1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00, 1'b0}),
      chk_row(ACT_SPARE_HI, 8'hFF, 1'b0,
              result_t'{1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 8'h00, 1'b0}),
      cfg_row(CFG_PHASE_TICKS, 16'h0000),
      cfg_row(CFG_WRITE_PROTECT, 16'h0001),
      chk_row(CMD_START, 8'hA5, 1'b1, result_t'{1'b1, 1'b1, 1'b1, 1'b0, ST_OK, 8'h00, 1'b1}),
      chk_row(CMD_WRITE, 8'h3C, 1'b1,
              result_t'{1'b1, 1'b1, 1'b1, 1'b0, ST_REJECTED, 8'h00, 1'b1}),
      req_row(ACT_SPARE_LO, 8'h00, 1'b1, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b0, 8'd2),
      req_row(CMD_START, 8'h00, 1'b0, 8'd1),
      chk_row(CMD_IDLE, 8'h00, 1'b0,
              result_t'{1'b1, 1'b1, 1'b0, 1'b1, ST_START_FAIL, 8'h00, 1'b1}),
      req_row(CMD_START, 8'hFF, 1'b1, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b1, 8'd1),
      chk_row(CMD_IDLE, 8'h00, 1'b1,
              result_t'{1'b1, 1'b0, 1'b0, 1'b1, ST_START_FAIL, 8'h00, 1'b1}),
      req_row(CMD_STOP, 8'h00, 1'b1, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b0, 8'd4),
      req_row(CMD_WRITE, 8'hFF, 1'b0, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b1, 8'd27),
      req_row(CMD_WRITE, 8'h00, 1'b1, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b0, 8'd26),
      chk_row(CMD_IDLE, 8'h00, 1'b0, result_t'{1'b0, 1'b1, 1'b0, 1'b1, ST_OK, 8'h00, 1'b1}),
      req_row(CMD_READ_ACK, 8'h00, 1'b1, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b1, 8'd20),
      req_row(CMD_READ_NACK, 8'h00, 1'b0, 8'd1),
      req_row(CMD_IDLE, 8'h00, 1'b0, 8'd20),
      cfg_row(CFG_WRITE_PROTECT, 16'h0000)
    };
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) begin
        write_register(row.cfg_idx, row.cfg_data);
      end else begin
        repeat (row.reps) issue_request(row.action, row.tx, row.sda, row.typed, row.want);
      end
    end

    // Random part: four idling regimes, each under three register settings with short phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 54;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 54;
        end
        default: begin
          in_idle_pct = 35;
          out_stall_pct = 35;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: write_register(CFG_PHASE_TICKS, 16'($urandom_range(1, 3)));
          1: write_register(CFG_PHASE_TICKS, 16'($urandom_range(0, 5)));
          default: write_register(CFG_PHASE_TICKS, 16'd1);
        endcase
        write_register(CFG_WRITE_PROTECT, 16'($urandom_range(0, 65535)));
        run_bus_traffic(130);
      end
    end

    // Drop valid, let the outstanding results drain, then allow the pipeline to settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    out_stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("i2c_master_byte_engine_core verification clean");
    end else begin
      $display("i2c_master_byte_engine_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_byte_engine_core.sv
test/i2c_master_byte_engine_core_tb.sv
